### hdl/blpw_pkg.sv
// ----------------------------------------------------------------------------
// blpw_pkg
// Shared types and constants of the line pixel writer: command and pixel
// records, register indexes, reset values of the screen registers.
// ----------------------------------------------------------------------------
package blpw_pkg;

    // coordinate and derived widths
    localparam int COORD_BITS = 10;
    localparam int LEFT_W     = COORD_BITS + 1;
    localparam int ERR_W      = COORD_BITS + 3;
    localparam int SIZE_W     = 11;
    localparam int STRIDE_W   = 8;
    localparam int ADDR_W     = 17;

    // default burst length
    localparam int BURST_DEF  = 64;

    // command queue depth
    localparam int QDEPTH     = 2;

    // operation codes
    localparam logic OP_START    = 1'b0;
    localparam logic OP_CONTINUE = 1'b1;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STRIDE = 2'd2;

    // register reset values
    localparam logic [SIZE_W-1:0]   WIDTH_RST  = 11'd800;
    localparam logic [SIZE_W-1:0]   HEIGHT_RST = 11'd600;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 8'd100;

    // screen configuration
    typedef struct packed {
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        logic [STRIDE_W-1:0] stride;
    } cfg_t;

    // classified command with precomputed line setup
    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic                  x_neg;
        logic                  y_neg;
        logic                  steep;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
        logic [ERR_W-1:0]      err;
        logic                  color;
    } cmd_t;

    // one emitted pixel
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ADDR_W-1:0]     addr;
        logic [2:0]            bit_idx;
        logic                  color;
        logic                  wr_en;
        logic                  burst_last;
        logic                  line_done;
    } pix_t;

endpackage

### hdl/blpw_front.sv
// ----------------------------------------------------------------------------
// blpw_front
// Input side: takes command transfers, classifies start and continue, and
// works out deltas, step directions, major axis and initial error.
// ----------------------------------------------------------------------------
module blpw_front
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,
    input  logic                  s_tuser,
    output logic                  push_valid,
    input  logic                  push_ready,
    output blpw_pkg::cmd_t        push_cmd
);

    localparam int CB = blpw_pkg::COORD_BITS;

    logic [CB-1:0]                 x0;
    logic [CB-1:0]                 y0;
    logic [CB-1:0]                 x1;
    logic [CB-1:0]                 y1;
    logic                          x_neg;
    logic                          y_neg;
    logic [CB-1:0]                 adx;
    logic [CB-1:0]                 ady;
    logic                          steep;
    logic [CB-1:0]                 major;
    logic [CB-1:0]                 minor;

    // field unpacking
    assign x0 = s_tdata[CB-1:0];
    assign y0 = s_tdata[2*CB-1:CB];
    assign x1 = s_tdata[3*CB-1:2*CB];
    assign y1 = s_tdata[4*CB-1:3*CB];

    // direction and absolute deltas
    assign x_neg = (x1 < x0);
    assign y_neg = (y1 < y0);
    assign adx   = x_neg ? (x0 - x1) : (x1 - x0);
    assign ady   = y_neg ? (y0 - y1) : (y1 - y0);

    // major axis selection
    assign steep = (ady > adx);
    assign major = steep ? ady : adx;
    assign minor = steep ? adx : ady;

    // command record
    always_comb
    begin
        push_cmd.op    = s_tuser;
        push_cmd.x0    = x0;
        push_cmd.y0    = y0;
        push_cmd.x_neg = x_neg;
        push_cmd.y_neg = y_neg;
        push_cmd.steep = steep;
        push_cmd.major = major;
        push_cmd.minor = minor;
        push_cmd.err   = {2'b00, minor, 1'b0} - {3'b000, major};
        push_cmd.color = s_tdata[4*CB];
    end

    // handshake straight onto the queue
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

### hdl/blpw_queue.sv
// ----------------------------------------------------------------------------
// blpw_queue
// Short command queue between the input side and the line walker.
// ----------------------------------------------------------------------------
module blpw_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  blpw_pkg::cmd_t        push_cmd,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output blpw_pkg::cmd_t        pop_cmd
);

    localparam int DEPTH = blpw_pkg::QDEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blpw_pkg::cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/blpw_back.sv
// ----------------------------------------------------------------------------
// blpw_back
// Line walker: takes commands from the queue, steps the Bresenham error one
// pixel a cycle unless stalled and fills the output reg with address, enables.
// ----------------------------------------------------------------------------
module blpw_back
#(
    parameter int BURST = blpw_pkg::BURST_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  blpw_pkg::cfg_t        cfg,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  blpw_pkg::cmd_t        cmd,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output blpw_pkg::pix_t        pix
);

    localparam int CB     = blpw_pkg::COORD_BITS;
    localparam int LW     = blpw_pkg::LEFT_W;
    localparam int EW     = blpw_pkg::ERR_W;
    localparam int AW     = blpw_pkg::ADDR_W;
    localparam int BCNT_W = (BURST > 1) ? $clog2(BURST) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [CB-1:0]         cur_x_reg;
    logic [CB-1:0]         cur_x_next;
    logic [CB-1:0]         cur_y_reg;
    logic [CB-1:0]         cur_y_next;
    logic [EW-1:0]         err_reg;
    logic [EW-1:0]         err_next;
    logic [CB-1:0]         major_reg;
    logic [CB-1:0]         major_next;
    logic [CB-1:0]         minor_reg;
    logic [CB-1:0]         minor_next;
    logic [LW-1:0]         left_reg;
    logic [LW-1:0]         left_next;
    logic                  x_neg_reg;
    logic                  x_neg_next;
    logic                  y_neg_reg;
    logic                  y_neg_next;
    logic                  steep_reg;
    logic                  steep_next;
    logic                  color_reg;
    logic                  color_next;
    logic [BCNT_W-1:0]     bcnt_reg;
    logic [BCNT_W-1:0]     bcnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    blpw_pkg::pix_t        out_reg;
    blpw_pkg::pix_t        out_next;

    logic                  out_free;
    logic                  emit;
    logic [LW-1:0]         left_dec;
    logic                  last_b;
    logic                  err_pos;
    logic [CB-1:0]         x_step;
    logic [CB-1:0]         y_step;
    logic [AW:0]           row_base;
    logic [AW:0]           addr_sum;

    assign out_free  = !out_valid_reg || pix_ready;
    assign emit      = (state_reg == ST_RUN) && out_free;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

    // per-pixel arithmetic
    assign left_dec = left_reg - 1'b1;
    assign last_b   = (bcnt_reg == BCNT_W'(BURST - 1)) || (left_dec == '0);
    assign err_pos  = !err_reg[EW-1];
    assign x_step   = x_neg_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
    assign y_step   = y_neg_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
    assign row_base = (AW+1)'(cur_y_reg) * (AW+1)'(cfg.stride);
    assign addr_sum = row_base + (AW+1)'(cur_x_reg >> 3);

    // walker control and next state
    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        err_next       = err_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        left_next      = left_reg;
        x_neg_next     = x_neg_reg;
        y_neg_next     = y_neg_reg;
        steep_next     = steep_reg;
        color_next     = color_reg;
        bcnt_next      = bcnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == blpw_pkg::OP_START)
                    begin
                        // a new line replaces whatever was pending
                        cur_x_next = cmd.x0;
                        cur_y_next = cmd.y0;
                        err_next   = cmd.err;
                        major_next = cmd.major;
                        minor_next = cmd.minor;
                        left_next  = {1'b0, cmd.major} + 1'b1;
                        x_neg_next = cmd.x_neg;
                        y_neg_next = cmd.y_neg;
                        steep_next = cmd.steep;
                        color_next = cmd.color;
                        bcnt_next  = '0;
                        state_next = ST_RUN;
                    end
                    else if (left_reg != '0)
                    begin
                        // resume a pending line
                        bcnt_next  = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_next.x          = cur_x_reg;
                    out_next.y          = cur_y_reg;
                    out_next.addr       = addr_sum[AW-1:0];
                    out_next.bit_idx    = cur_x_reg[2:0];
                    out_next.color      = color_reg;
                    out_next.wr_en      = ({1'b0, cur_x_reg} < cfg.width) &&
                                          ({1'b0, cur_y_reg} < cfg.height);
                    out_next.burst_last = last_b;
                    out_next.line_done  = (left_dec == '0);
                    left_next           = left_dec;
                    bcnt_next           = bcnt_reg + 1'b1;
                    // error step toward the next pixel
                    if (left_dec != '0)
                    begin
                        if (steep_reg)
                        begin
                            cur_y_next = y_step;
                            if (err_pos)
                            begin
                                cur_x_next = x_step;
                            end
                        end
                        else
                        begin
                            cur_x_next = x_step;
                            if (err_pos)
                            begin
                                cur_y_next = y_step;
                            end
                        end
                        err_next = err_reg + {2'b00, minor_reg, 1'b0} -
                                   (err_pos ? {2'b00, major_reg, 1'b0} : '0);
                    end
                    if (last_b)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register valid
        if (out_free)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            left_reg      <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            steep_reg     <= 1'b0;
            color_reg     <= 1'b0;
            bcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            err_reg       <= err_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            left_reg      <= left_next;
            x_neg_reg     <= x_neg_next;
            y_neg_reg     <= y_neg_next;
            steep_reg     <= steep_next;
            color_reg     <= color_next;
            bcnt_reg      <= bcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

### hdl/bresenham_line_pixel_writer.sv
// ----------------------------------------------------------------------------
// bresenham_line_pixel_writer
// Walks lines on a one-bit-per-pixel framebuffer and emits one pixel write
// per transfer with byte address, bit index, colour and on-screen enable.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    line command, tuser = operation
//   m_*       out   m_tvalid/m_tready    pixel, tlast = burst end
//   cfg_*     in    cfg_we               screen width, height, row stride
//
// The walker emits one pixel per cycle from its single error update unless
// m_tready stalls; an item gives at most BURST pixels and is fetched from the
// two-entry command queue. Commands are taken while the walker runs until the
// queue is full. Reset clears the walker, queue and output valid flag and loads
// the screen registers with 800, 600 and 100. A stalled m_tready holds the
// pixel in the output register and freezes the walker.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_writer
#(
    parameter int BURST = blpw_pkg::BURST_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_x, start_y, end_x, end_y, pen_color, zero fill
    input  logic [47:0] s_tdata,
    // operation
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_x, pixel_y, byte_address, bit_index, write_color, write_enable,
    // zero fill
    output logic [47:0] m_tdata,
    // burst_last
    output logic        m_tlast,
    // line_done
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    blpw_pkg::cfg_t   cfg_reg;
    blpw_pkg::cmd_t   push_cmd;
    blpw_pkg::cmd_t   pop_cmd;
    blpw_pkg::pix_t   pix;
    logic             push_valid;
    logic             push_ready;
    logic             pop_valid;
    logic             pop_ready;

    // screen registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= blpw_pkg::WIDTH_RST;
            cfg_reg.height <= blpw_pkg::HEIGHT_RST;
            cfg_reg.stride <= blpw_pkg::STRIDE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                blpw_pkg::REG_WIDTH:  cfg_reg.width  <= cfg_data;
                blpw_pkg::REG_HEIGHT: cfg_reg.height <= cfg_data;
                blpw_pkg::REG_STRIDE: cfg_reg.stride <= cfg_data[blpw_pkg::STRIDE_W-1:0];
                default:              cfg_reg        <= cfg_reg;
            endcase
        end
    end

    blpw_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    blpw_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    blpw_back #(.BURST(BURST)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd        (pop_cmd),
        .pix_valid  (m_tvalid),
        .pix_ready  (m_tready),
        .pix        (pix)
    );

    // output packing
    assign m_tdata = {6'b000000, pix.wr_en, pix.color, pix.bit_idx, pix.addr, pix.y, pix.x};
    assign m_tlast = pix.burst_last;
    assign m_tuser = pix.line_done;

endmodule
